/* src/itin_pkg.sv */
package itin_pkg;

    // Width of one airport code: three ASCII letters.
    localparam int CODE_W = 24;

    // Airport where every itinerary begins after reset.
    localparam logic [CODE_W-1:0] START_RESET = 24'h4A464B;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_NONE  = 2'd1,
        ST_DROP  = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;       // store the ticket of the accepted word
        logic    init;       // start a search at the start airport
        logic    scan_clr;   // restart the ticket scan
        logic    scan;       // advance the ticket scan
        logic    push;       // take the best ticket found by the scan
        logic    pop;        // drop the top ticket from the path stack
        logic    pop_load;   // return the popped ticket and set the floor
        logic    stk_emit;   // path stack read at the emit index
        logic    rd_stack;   // ticket store read at the slot from the stack
        logic    emit_begin; // emit index to zero
        logic    emit_adv;   // emit index to the next entry
        logic    out_load;   // load the output register
        logic    out_mem;    // output airport from the store, else start
        logic    out_last;   // last stop flag of the loaded word
        t_status out_status; // status of the loaded word
        logic    finish;     // clear the ticket store
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic best_valid;
        logic depth_zero;
        logic depth_eq_count;
        logic depth_full;
        logic emit_last;
        logic out_free;
        logic overflow;
    } t_stat;

endpackage

/* src/itin_ctrl.sv */
module itin_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_action,
    input  itin_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output itin_pkg::t_cmd  o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SCAN  = 10'b0000000010,
        S_POP_A = 10'b0000000100,
        S_POP_S = 10'b0000001000,
        S_POP_M = 10'b0000010000,
        S_RES   = 10'b0000100000,
        S_EM_ST = 10'b0001000000,
        S_EM_A  = 10'b0010000000,
        S_EM_S  = 10'b0100000000,
        S_EM_M  = 10'b1000000000
    } t_state;

    t_state            r_state, n_state;
    itin_pkg::t_status r_code, n_code;

    // State and single-result code registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= itin_pkg::ST_FOUND;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.out_status = itin_pkg::ST_FOUND;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_action) begin
                        o_cmd.load = 1'b1;
                    end else if (i_stat.overflow) begin
                        n_code  = itin_pkg::ST_DROP;
                        n_state = S_RES;
                    end else begin
                        o_cmd.init     = 1'b1;
                        o_cmd.scan_clr = 1'b1;
                        n_state        = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    if (i_stat.best_valid && !i_stat.depth_full) begin
                        o_cmd.push     = 1'b1;
                        o_cmd.scan_clr = 1'b1;
                    end else if (i_stat.depth_eq_count) begin
                        n_state = S_EM_ST;
                    end else if (i_stat.depth_zero) begin
                        n_code  = itin_pkg::ST_NONE;
                        n_state = S_RES;
                    end else begin
                        o_cmd.pop = 1'b1;
                        n_state   = S_POP_A;
                    end
                end
            end
            S_POP_A: begin
                n_state = S_POP_S;
            end
            S_POP_S: begin
                o_cmd.rd_stack = 1'b1;
                n_state        = S_POP_M;
            end
            S_POP_M: begin
                o_cmd.pop_load = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_state        = S_SCAN;
            end
            S_RES: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_last   = 1'b1;
                    o_cmd.out_status = r_code;
                    o_cmd.finish     = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_EM_ST: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = i_stat.depth_zero;
                    if (i_stat.depth_zero) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.emit_begin = 1'b1;
                        n_state          = S_EM_A;
                    end
                end
            end
            S_EM_A: begin
                o_cmd.stk_emit = 1'b1;
                n_state        = S_EM_S;
            end
            S_EM_S: begin
                o_cmd.stk_emit = 1'b1;
                o_cmd.rd_stack = 1'b1;
                n_state        = S_EM_M;
            end
            S_EM_M: begin
                // Keep the store read on the stack slot so the airport holds while stalled.
                o_cmd.stk_emit = 1'b1;
                o_cmd.rd_stack = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_mem  = 1'b1;
                    o_cmd.out_last = i_stat.emit_last;
                    if (i_stat.emit_last) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.emit_adv = 1'b1;
                        n_state        = S_EM_A;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A ticket is taken only when the scan found one.
    a_push_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> i_stat.best_valid)
        else $error("push without a candidate ticket");

    // A single result is only a failure or a dropped-ticket report.
    a_res_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RES) |-> (r_code == itin_pkg::ST_NONE || r_code == itin_pkg::ST_DROP))
        else $error("single result with found status");

    // The output register is loaded only when it is free.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("output overwritten");

endmodule

/* src/itin_dp.sv */
module itin_dp #(
    parameter int MAX_TICKETS = 32,
    parameter int CW = 6,
    parameter int SW = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  itin_pkg::t_cmd                i_cmd,
    output itin_pkg::t_stat               o_stat,
    input  logic                          i_cfg_we,
    input  logic [itin_pkg::CODE_W-1:0]   i_cfg_wdata,
    input  logic [itin_pkg::CODE_W-1:0]   i_from_airport,
    input  logic [itin_pkg::CODE_W-1:0]   i_to_airport,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [itin_pkg::CODE_W-1:0]   o_airport,
    output logic                          o_last_stop,
    output logic [1:0]                    o_status
);

    localparam int AW = itin_pkg::CODE_W;

    // Ticket store and path stack.
    logic [AW-1:0] mem_org [MAX_TICKETS];
    logic [AW-1:0] mem_dst [MAX_TICKETS];
    logic [SW-1:0] mem_stk [MAX_TICKETS];

    logic [AW-1:0]      r_start;
    logic [MAX_TICKETS-1:0] r_used;
    logic [CW-1:0]      r_count;
    logic               r_overflow;
    logic [CW-1:0]      r_depth;
    logic [CW-1:0]      r_emit;
    logic [AW-1:0]      r_here;
    logic               r_has_floor;
    logic [AW+SW-1:0]   r_floor;
    logic [CW-1:0]      r_scan_addr;
    logic               r_rd_vld;
    logic [SW-1:0]      r_rd_idx;
    logic [AW-1:0]      r_rd_org;
    logic [AW-1:0]      r_rd_dst;
    logic [SW-1:0]      r_stk_q;
    logic               r_best_vld;
    logic [AW+SW-1:0]   r_best;
    logic               r_out_vld;
    logic [AW-1:0]      r_out_airport;
    logic               r_out_last;
    itin_pkg::t_status  r_out_status;

    logic               full;
    logic               scan_issue;
    logic [SW-1:0]      rd_addr;
    logic [SW-1:0]      stk_addr;
    logic [AW+SW-1:0]   cand_key;
    logic               cand_ok;
    logic               out_free;

    assign full       = (r_count == CW'(MAX_TICKETS));
    assign scan_issue = i_cmd.scan && (r_scan_addr < r_count);
    assign rd_addr    = i_cmd.rd_stack ? r_stk_q : r_scan_addr[SW-1:0];
    assign stk_addr   = i_cmd.stk_emit ? r_emit[SW-1:0] : r_depth[SW-1:0];
    assign cand_key   = {r_rd_dst, r_rd_idx};
    assign out_free   = !r_out_vld || i_out_ready;

    // A scanned ticket qualifies if unused, leaving here, above the floor and below the best.
    assign cand_ok = r_rd_vld && !r_used[r_rd_idx] && (r_rd_org == r_here)
                     && (!r_has_floor || (cand_key > r_floor))
                     && (!r_best_vld || (cand_key < r_best));

    // Store writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !full) begin
            mem_org[r_count[SW-1:0]] <= i_from_airport;
            mem_dst[r_count[SW-1:0]] <= i_to_airport;
        end
        if (i_cmd.push) begin
            mem_stk[r_depth[SW-1:0]] <= r_best[SW-1:0];
        end
        r_rd_org <= mem_org[rd_addr];
        r_rd_dst <= mem_dst[rd_addr];
        r_stk_q  <= mem_stk[stk_addr];
    end

    // Start airport register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= itin_pkg::START_RESET;
        end else if (i_cfg_we) begin
            r_start <= i_cfg_wdata;
        end
    end

    // Used bits, counts and search position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_depth     <= '0;
            r_emit      <= '0;
            r_has_floor <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (full) begin
                    r_overflow <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.init) begin
                r_depth     <= '0;
                r_has_floor <= 1'b0;
            end
            if (i_cmd.push) begin
                r_used[r_best[SW-1:0]] <= 1'b1;
                r_depth     <= r_depth + 1'b1;
                r_has_floor <= 1'b0;
            end
            if (i_cmd.pop) begin
                r_depth <= r_depth - 1'b1;
            end
            if (i_cmd.pop_load) begin
                r_used[r_stk_q] <= 1'b0;
                r_has_floor     <= 1'b1;
            end
            if (i_cmd.emit_begin) begin
                r_emit <= '0;
            end else if (i_cmd.emit_adv) begin
                r_emit <= r_emit + 1'b1;
            end
            if (i_cmd.finish) begin
                r_used     <= '0;
                r_count    <= '0;
                r_overflow <= 1'b0;
                r_depth    <= '0;
            end
        end
    end

    // Current airport and floor key.
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_here <= r_start;
        end else if (i_cmd.push) begin
            r_here <= r_best[AW+SW-1:SW];
        end else if (i_cmd.pop_load) begin
            r_here  <= r_rd_org;
            r_floor <= {r_rd_dst, r_stk_q};
        end
    end

    // Scan over the store: one read issued per cycle, compared in the cycle after.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_addr <= '0;
            r_rd_vld    <= 1'b0;
            r_best_vld  <= 1'b0;
        end else if (i_cmd.scan_clr) begin
            r_scan_addr <= '0;
            r_rd_vld    <= 1'b0;
            r_best_vld  <= 1'b0;
        end else begin
            r_rd_vld <= scan_issue;
            if (scan_issue) begin
                r_scan_addr <= r_scan_addr + 1'b1;
            end
            if (cand_ok) begin
                r_best_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_issue) begin
            r_rd_idx <= r_scan_addr[SW-1:0];
        end
        if (cand_ok) begin
            r_best <= cand_key;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_airport <= i_cmd.out_mem ? r_rd_dst : r_start;
            r_out_last    <= i_cmd.out_last;
            r_out_status  <= i_cmd.out_status;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_airport   = r_out_airport;
    assign o_last_stop = r_out_last;
    assign o_status    = r_out_status;

    // Status to the controller.
    always_comb begin
        o_stat.scan_done      = i_cmd.scan && !r_rd_vld && (r_scan_addr >= r_count);
        o_stat.best_valid     = r_best_vld;
        o_stat.depth_zero     = (r_depth == '0);
        o_stat.depth_eq_count = (r_depth == r_count);
        o_stat.depth_full     = (r_depth == CW'(MAX_TICKETS));
        o_stat.emit_last      = ((r_emit + 1'b1) == r_depth);
        o_stat.out_free       = out_free;
        o_stat.overflow       = r_overflow;
    end

    // The path never holds more tickets than the store.
    a_depth_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= r_count)
        else $error("path deeper than ticket store");

    // After a compute item the store is empty.
    a_finish_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_count == '0 && r_used == '0 && !r_overflow))
        else $error("store not cleared");

    // A taken ticket is marked used.
    a_push_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |=> r_used[$past(r_best[SW-1:0])])
        else $error("pushed ticket not marked used");

endmodule

/* src/itinerary_euler_path_search.sv */
// Channel   Handshake                   Word
// input     i_in_valid / o_in_ready     i_action, i_from_airport, i_to_airport
// output    o_out_valid / i_out_ready   o_airport, o_last_stop, o_status
// config    i_cfg_we                    i_cfg_wdata (start airport)
//
// A load word is stored as it is accepted; loads are accepted while a result word still waits.
// A compute word runs one scan of the store per step of the walk; a take-back passes
// through S_POP_A, S_POP_S and S_POP_M first, so the time grows with the backtracking.
// Each airport after the first goes through S_EM_A, S_EM_S and S_EM_M, set by the stack and
// store read ports. Each result word waits for i_out_ready and emission pauses meanwhile.
// Reset is synchronous, active low, and clears the used bits at once.
module itinerary_euler_path_search #(
    parameter int MAX_TICKETS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [23:0] i_from_airport,
    input  logic [23:0] i_to_airport,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [23:0] o_airport,
    output logic        o_last_stop,
    output logic [1:0]  o_status,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata
);

    localparam int CW = $clog2(MAX_TICKETS + 1);
    localparam int SW = (MAX_TICKETS > 1) ? $clog2(MAX_TICKETS) : 1;

    itin_pkg::t_cmd  cmd;
    itin_pkg::t_stat stat;

    // Search controller.
    itin_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Ticket store, path stack and output register.
    itin_dp #(
        .MAX_TICKETS (MAX_TICKETS),
        .CW          (CW),
        .SW          (SW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_from_airport (i_from_airport),
        .i_to_airport   (i_to_airport),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_airport      (o_airport),
        .o_last_stop    (o_last_stop),
        .o_status       (o_status)
    );

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int SLOTS = 32;
    localparam int DRAIN_CYCLES = 60;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic                        i_action = 1'b0;
    logic [itin_pkg::CODE_W-1:0] i_from_airport = '0;
    logic [itin_pkg::CODE_W-1:0] i_to_airport = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic [itin_pkg::CODE_W-1:0] o_airport;
    logic                        o_last_stop;
    logic [1:0]                  o_status;
    logic                        i_cfg_we = 1'b0;
    logic [itin_pkg::CODE_W-1:0] i_cfg_wdata = '0;

    itinerary_euler_path_search dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_from_airport (i_from_airport),
        .i_to_airport   (i_to_airport),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_airport      (o_airport),
        .o_last_stop    (o_last_stop),
        .o_status       (o_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    // Expected itinerary words, oldest first.
    logic [itin_pkg::CODE_W-1:0] stop_q[$];
    logic                        last_q[$];
    itin_pkg::t_status           status_q[$];

    // Shadow copy of the ticket store and search state.
    logic [itin_pkg::CODE_W-1:0] shadow_from[SLOTS];
    logic [itin_pkg::CODE_W-1:0] shadow_to[SLOTS];
    bit                          shadow_used[SLOTS];
    int                          shadow_path[SLOTS];
    int                          shadow_count = 0;
    bit                          shadow_drop = 0;
    logic [itin_pkg::CODE_W-1:0] shadow_start = itin_pkg::START_RESET;

    int  errors = 0;
    int  words_sent = 0;
    int  words_checked = 0;
    int  searches = 0;
    bit  calm = 0;

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h, expected %h (word %0d)", what, got, want,
                 words_checked);
        errors++;
    endtask

    function automatic void clear_shadow();
        for (int i = 0; i < SLOTS; i++) shadow_used[i] = 0;
        shadow_count = 0;
        shadow_drop = 0;
    endfunction

    function automatic void push_stop(logic [itin_pkg::CODE_W-1:0] code, logic last,
                                      itin_pkg::t_status st);
        stop_q.insert(stop_q.size(), code);
        last_q.insert(last_q.size(), last);
        status_q.insert(status_q.size(), st);
    endfunction

    // Walk the shadow store the same way the block does and queue its itinerary.
    function automatic void plan_itinerary();
        logic [itin_pkg::CODE_W-1:0] here;
        logic [30:0]                 floor_key;
        logic [30:0]                 key;
        logic [30:0]                 best_key;
        int                          best;
        int                          depth;
        int                          slot;
        searches++;
        if (shadow_drop) begin
            push_stop(shadow_start, 1'b1, itin_pkg::ST_DROP);
            clear_shadow();
            return;
        end
        here = shadow_start;
        floor_key = '0;
        depth = 0;
        forever begin
            best = -1;
            best_key = '0;
            for (int i = 0; i < shadow_count; i++) begin
                key = {1'b0, shadow_to[i], 6'(i)};
                if (!shadow_used[i] && shadow_from[i] == here && key >= floor_key &&
                    (best < 0 || key < best_key)) begin
                    best = i;
                    best_key = key;
                end
            end
            if (best >= 0 && depth < SLOTS) begin
                shadow_used[best] = 1;
                shadow_path[depth] = best;
                depth++;
                here = shadow_to[best];
                floor_key = '0;
            end else if (depth == shadow_count) begin
                break;
            end else if (depth == 0) begin
                push_stop(shadow_start, 1'b1, itin_pkg::ST_NONE);
                clear_shadow();
                return;
            end else begin
                depth--;
                slot = shadow_path[depth];
                shadow_used[slot] = 0;
                here = shadow_from[slot];
                floor_key = {1'b0, shadow_to[slot], 6'(slot)} + 31'd1;
            end
        end
        push_stop(shadow_start, depth == 0, itin_pkg::ST_FOUND);
        for (int i = 0; i < depth; i++)
            push_stop(shadow_to[shadow_path[i]], i == depth - 1, itin_pkg::ST_FOUND);
        clear_shadow();
    endfunction

    function automatic void predict_word(logic act, logic [itin_pkg::CODE_W-1:0] src,
                                         logic [itin_pkg::CODE_W-1:0] dst);
        if (act) begin
            plan_itinerary();
        end else if (shadow_count < SLOTS) begin
            shadow_from[shadow_count] = src;
            shadow_to[shadow_count] = dst;
            shadow_used[shadow_count] = 0;
            shadow_count++;
        end else begin
            shadow_drop = 1;
        end
    endfunction

    // Send one word; called just after a rising edge, returns just after acceptance.
    task automatic send_word(input logic act, input logic [itin_pkg::CODE_W-1:0] src,
                             input logic [itin_pkg::CODE_W-1:0] dst);
        int gap;
        gap = (!calm && $urandom_range(99) < 10) ? 1 : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_from_airport <= src;
        i_to_airport   <= dst;
        do @(posedge i_clk); while (!o_in_ready);
        predict_word(act, src, dst);
        words_sent++;
    endtask

    task automatic load_ticket(input logic [itin_pkg::CODE_W-1:0] src,
                               input logic [itin_pkg::CODE_W-1:0] dst);
        send_word(1'b0, src, dst);
    endtask

    task automatic run_search();
        send_word(1'b1, 24'($urandom), 24'($urandom));
    endtask

    // Drain all results, then let the block settle before touching the register.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (stop_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_start(input logic [itin_pkg::CODE_W-1:0] code);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= code;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_start = code;
        @(posedge i_clk);
    endtask

    // Compare every accepted result word with the oldest expectation.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (stop_q.size() == 0) begin
                    report_mismatch("unexpected word", {8'h0, o_airport}, 32'h0);
                end else begin
                    if (o_airport !== stop_q[0])
                        report_mismatch("airport", {8'h0, o_airport}, {8'h0, stop_q[0]});
                    if (o_last_stop !== last_q[0])
                        report_mismatch("last_stop", {31'h0, o_last_stop},
                                        {31'h0, last_q[0]});
                    if (o_status !== status_q[0])
                        report_mismatch("status", {30'h0, o_status}, {30'h0, status_q[0]});
                    void'(stop_q.pop_front());
                    void'(last_q.pop_front());
                    void'(status_q.pop_front());
                end
                words_checked++;
            end
            i_out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 10);
        end
    end

    task automatic test_default_start();
        run_search();
        load_ticket("JFK", "SFO");
        load_ticket("JFK", "ATL");
        load_ticket("SFO", "ATL");
        load_ticket("ATL", "JFK");
        load_ticket("ATL", "SFO");
        run_search();
        // The smallest first choice is a dead end, so the walk must back up.
        load_ticket("JFK", "KUL");
        load_ticket("JFK", "NRT");
        load_ticket("NRT", "JFK");
        run_search();
    endtask

    task automatic test_special_cases();
        // Disconnected tickets leave no itinerary.
        load_ticket("JFK", "AAA");
        load_ticket("BBB", "CCC");
        run_search();
        // Duplicate tickets are taken in store order.
        load_ticket("JFK", "AAA");
        load_ticket("AAA", "JFK");
        load_ticket("JFK", "AAA");
        load_ticket("AAA", "JFK");
        run_search();
    endtask

    task automatic test_code_extremes();
        set_start(24'hFFFFFF);
        load_ticket(24'hFFFFFF, 24'h000000);
        load_ticket(24'h000000, 24'hFFFFFF);
        load_ticket(24'hFFFFFF, 24'h555555);
        load_ticket(24'h555555, 24'hAAAAAA);
        run_search();
        run_search();
        set_start(24'h000000);
        load_ticket(24'h000000, 24'hFFFFFF);
        run_search();
    endtask

    task automatic test_full_store();
        // A full chain of tickets, loaded in reverse so the search has to scan.
        for (int i = SLOTS - 1; i >= 0; i--)
            load_ticket(24'(i), 24'(i + 1));
        run_search();
        // One ticket too many is dropped and the search is refused.
        for (int i = 0; i <= SLOTS; i++)
            load_ticket(24'(i), 24'(i + 1));
        run_search();
        run_search();
    endtask

    task automatic random_set();
        logic [itin_pkg::CODE_W-1:0] codes[4];
        logic [itin_pkg::CODE_W-1:0] walk_from[8];
        logic [itin_pkg::CODE_W-1:0] walk_to[8];
        logic [itin_pkg::CODE_W-1:0] tmp;
        logic [itin_pkg::CODE_W-1:0] here;
        int n;
        int j;
        n = $urandom_range(1, 7);
        codes[0] = shadow_start;
        for (int i = 1; i < 4; i++) codes[i] = 24'($urandom);
        if ($urandom_range(9) < 7) begin
            here = shadow_start;
            for (int i = 0; i < n; i++) begin
                walk_from[i] = here;
                walk_to[i] = codes[$urandom_range(3)];
                here = walk_to[i];
            end
            for (int i = n - 1; i > 0; i--) begin
                j = $urandom_range(i);
                tmp = walk_from[i]; walk_from[i] = walk_from[j]; walk_from[j] = tmp;
                tmp = walk_to[i]; walk_to[i] = walk_to[j]; walk_to[j] = tmp;
            end
        end else begin
            for (int i = 0; i < n; i++) begin
                walk_from[i] = ($urandom_range(3) == 0) ? 24'($urandom)
                                                         : codes[$urandom_range(3)];
                walk_to[i] = ($urandom_range(3) == 0) ? 24'($urandom)
                                                       : codes[$urandom_range(3)];
            end
        end
        for (int i = 0; i < n; i++) load_ticket(walk_from[i], walk_to[i]);
        run_search();
    endtask

    task automatic test_random();
        int first;
        first = words_sent;
        set_start(24'($urandom));
        while (words_sent - first < 180) begin
            calm = (words_sent - first > 40 && words_sent - first < 140);
            random_set();
        end
        calm = 0;
        set_start(24'($urandom));
        while (words_sent - first < 365) random_set();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_start();
        test_special_cases();
        test_code_extremes();
        test_full_store();
        test_random();
        wait_idle();
        $display("Sent %0d words and ran %0d searches, checking %0d itinerary words.",
                 words_sent, searches, words_checked);
        $display("Covered dead ends, missing paths, dropped tickets and code extremes.");
        if (errors == 0 && stop_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
